// ===== src/avtsr_pkg.sv =====
// avtsr_pkg: shared types and constants for the timestamp rebaser
// word layouts for the request, internal command and response queues
// no dependencies
package avtsr_pkg;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int TS_W   = 64;
   localparam int STEP_W = 16;
   localparam logic [STEP_W-1:0] STEP_RESET = 16'd10;

   localparam logic [1:0] MODE_VIDEO = 2'd0;
   localparam logic [1:0] MODE_AUDIO = 2'd1;
   localparam logic       KIND_VIDEO = 1'b0;
   localparam logic       KIND_AUDIO = 1'b1;

   typedef struct packed {
      logic [1:0]             mode;
      logic signed [TS_W-1:0] in_dts;
      logic signed [TS_W-1:0] in_pts;
   } req_type;

   typedef struct packed {
      logic                   kind;
      logic signed [TS_W-1:0] dts;
      logic signed [TS_W-1:0] pts;
   } cmd_type;

   typedef struct packed {
      logic                   out_kind;
      logic signed [TS_W-1:0] out_dts;
      logic signed [TS_W-1:0] out_pts;
      logic                   reversed;
   } rsp_type;

endpackage

// ===== src/avtsr_front.sv =====
// avtsr_front: accepts request words, drops ignored packet kinds and
// queues video/audio words for the back end in a short fifo
// depends on avtsr_pkg
module avtsr_front (
   input  logic              clock,
   input  logic              reset,
   input  avtsr_pkg::req_type req_data,
   input  logic              req_push,
   output logic              req_full,
   output avtsr_pkg::cmd_type cmd_data,
   output logic              cmd_empty,
   input  logic              cmd_pop
);
   import avtsr_pkg::*;

   cmd_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                accept, keep, pop_ok;
   cmd_type             cmd_new;

   assign req_full  = (count_ff == QCNT_W'(QDEPTH));
   assign cmd_empty = (count_ff == '0);
   assign cmd_data  = mem_ff[rd_ptr_ff];

   assign accept = req_push && !req_full;
   assign keep   = accept && (req_data.mode == MODE_VIDEO || req_data.mode == MODE_AUDIO);
   assign pop_ok = cmd_pop && !cmd_empty;

   always_comb begin
      cmd_new.kind = (req_data.mode == MODE_AUDIO) ? KIND_AUDIO : KIND_VIDEO;
      cmd_new.dts  = req_data.in_dts;
      cmd_new.pts  = req_data.in_pts;
      wr_ptr_in    = keep ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff + QCNT_W'(keep) - QCNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== src/avtsr_back.sv =====
// avtsr_back: per-track timestamp state, rebasing datapath shared by both
// tracks, and the response fifo toward the consumer
// depends on avtsr_pkg
module avtsr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [avtsr_pkg::STEP_W-1:0]   step,
   input  avtsr_pkg::cmd_type              cmd_data,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   output avtsr_pkg::rsp_type              rsp_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop
);
   import avtsr_pkg::*;

   logic signed [TS_W-1:0] v_base_dts_ff, v_base_dts_in;
   logic signed [TS_W-1:0] v_base_pts_ff, v_base_pts_in;
   logic signed [TS_W-1:0] v_last_ff, v_last_in;
   logic signed [TS_W-1:0] v_out_dts_ff, v_out_dts_in;
   logic signed [TS_W-1:0] v_out_pts_ff, v_out_pts_in;
   logic signed [TS_W-1:0] a_base_ff, a_base_in;
   logic signed [TS_W-1:0] a_last_ff, a_last_in;
   logic signed [TS_W-1:0] a_out_ff, a_out_in;

   rsp_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                rq_full, take, pop_ok;

   logic                   is_audio, pull, rev;
   logic signed [TS_W-1:0] own_base, own_base_pts, own_out_dts, own_out_pts;
   logic signed [TS_W-1:0] oth_base, oth_last, pts_op, elapsed, step_x;
   logic signed [TS_W-1:0] nb_dts, nb_pts, no_dts, no_pts;
   rsp_type                res;

   assign rq_full   = (count_ff == QCNT_W'(QDEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign take      = !cmd_empty && !rq_full;
   assign cmd_pop   = take;
   assign pop_ok    = rsp_pop && !rsp_empty;

   // one datapath serves both tracks; audio uses dts as its pts operand
   always_comb begin
      is_audio     = (cmd_data.kind == KIND_AUDIO);
      own_base     = is_audio ? a_base_ff : v_base_dts_ff;
      own_base_pts = is_audio ? a_base_ff : v_base_pts_ff;
      own_out_dts  = is_audio ? a_out_ff  : v_out_dts_ff;
      own_out_pts  = is_audio ? a_out_ff  : v_out_pts_ff;
      oth_base     = is_audio ? v_base_dts_ff : a_base_ff;
      oth_last     = is_audio ? v_last_ff     : a_last_ff;
      pts_op       = is_audio ? cmd_data.dts  : cmd_data.pts;
      step_x       = $signed({{(TS_W-STEP_W){1'b0}}, step});

      // other track started and moved past its base
      pull    = (oth_base > 0) && (oth_base < oth_last);
      elapsed = pull ? oth_last - oth_base : '0;
      rev     = 1'b0;

      priority if (own_base[TS_W-1]) begin
         nb_dts = cmd_data.dts - elapsed;
         nb_pts = pts_op - elapsed;
         no_dts = elapsed;
         no_pts = elapsed;
      end else if (cmd_data.dts <= own_out_dts) begin
         nb_dts = cmd_data.dts - own_out_dts;
         nb_pts = pts_op - own_out_pts;
         no_dts = own_out_dts + step_x;
         no_pts = own_out_pts + step_x;
         rev    = 1'b1;
      end else begin
         nb_dts = own_base;
         nb_pts = own_base_pts;
         no_dts = cmd_data.dts - own_base;
         no_pts = pts_op - own_base_pts;
      end

      res.out_kind = cmd_data.kind;
      res.out_dts  = no_dts;
      res.out_pts  = no_pts;
      res.reversed = rev;

      v_base_dts_in = v_base_dts_ff;
      v_base_pts_in = v_base_pts_ff;
      v_last_in     = v_last_ff;
      v_out_dts_in  = v_out_dts_ff;
      v_out_pts_in  = v_out_pts_ff;
      a_base_in     = a_base_ff;
      a_last_in     = a_last_ff;
      a_out_in      = a_out_ff;
      if (take) begin
         if (is_audio) begin
            a_base_in = nb_dts;
            a_last_in = cmd_data.dts;
            a_out_in  = no_dts;
         end else begin
            v_base_dts_in = nb_dts;
            v_base_pts_in = nb_pts;
            v_last_in     = cmd_data.dts;
            v_out_dts_in  = no_dts;
            v_out_pts_in  = no_pts;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_base_dts_ff <= '1;
         v_base_pts_ff <= '0;
         v_last_ff     <= '0;
         v_out_dts_ff  <= '0;
         v_out_pts_ff  <= '0;
         a_base_ff     <= '1;
         a_last_ff     <= '0;
         a_out_ff      <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         v_base_dts_ff <= v_base_dts_in;
         v_base_pts_ff <= v_base_pts_in;
         v_last_ff     <= v_last_in;
         v_out_dts_ff  <= v_out_dts_in;
         v_out_pts_ff  <= v_out_pts_in;
         a_base_ff     <= a_base_in;
         a_last_ff     <= a_last_in;
         a_out_ff      <= a_out_in;
         wr_ptr_ff     <= take ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
         rd_ptr_ff     <= pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
         count_ff      <= count_ff + QCNT_W'(take) - QCNT_W'(pop_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("response fifo count out of range");

   a_audio_pts: assert property (@(posedge clock) disable iff (reset)
      take && is_audio |-> res.out_pts == res.out_dts)
      else $error("audio word with pts differing from dts");

   a_video_rev_step: assert property (@(posedge clock) disable iff (reset)
      take && !is_audio && rev |=>
         v_out_dts_ff == $past(v_out_dts_ff) + $past(step_x))
      else $error("video reversal did not advance by step");

   a_audio_first: assert property (@(posedge clock) disable iff (reset)
      take && is_audio && a_base_ff[TS_W-1] && !pull |=> a_out_ff == '0)
      else $error("first audio word without pull-back not at zero");

endmodule

// ===== src/av_timestamp_rebaser.sv =====
// av_timestamp_rebaser: top level, joins the front queue and the back end
// and holds the reverse_step control register
// depends on avtsr_pkg, avtsr_front, avtsr_back
//
// Takes one packet word per clock while not full, and sustains one word
// per clock when the consumer keeps popping. A video or audio word is
// registered into the two-deep front fifo, then passes through the
// combinational rebasing datapath into the two-deep response fifo.
// That datapath is two dependent 64-bit subtracts deep per track update (the
// other track's elapsed time, then the pulled-back base), which sets the clock.
// Ignored packet kinds are dropped at the front and
// produce no response. The reverse_step register is written through the csr
// port, which is always ready; write it only while no words are in flight.
module av_timestamp_rebaser (
   input  logic                         clock,
   input  logic                         reset,
   input  avtsr_pkg::req_type            req_data,
   input  logic                         push,
   output logic                         full,
   output avtsr_pkg::rsp_type            rsp_data,
   output logic                         empty,
   input  logic                         pop,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [avtsr_pkg::STEP_W-1:0] csr_wdata
);
   import avtsr_pkg::*;

   logic [STEP_W-1:0] step_ff;
   cmd_type           cmd_data;
   logic              cmd_empty, cmd_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         step_ff <= csr_wdata;
      end
   end

   avtsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_push  (push),
      .req_full  (full),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop)
   );

   avtsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .step      (step_ff),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

endmodule
